FILE: hw/rtl/tad_pkg.sv
`default_nettype none

package tad_pkg;

  // Default sizes
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 16;

  // Stream word widths
  localparam int IN_W  = 64;
  localparam int OUT_W = 16;

  // Sample fields
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;

  // CORDIC datapath: samples scaled by 2^14, room for the CORDIC gain
  localparam int SCALE_SH = 14;
  localparam int XZ_W     = 34;
  localparam int FRAC_W   = 16;
  localparam int ANG_W    = 26;
  localparam int ATAN_W   = 22;
  localparam int ATAN_N   = 24;

  // Angle widths
  localparam int DEG_W  = 9;
  localparam int TILT_W = 10;

  // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
  localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [ATAN_N] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  // 180 degrees in the accumulator format
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);

  localparam logic signed [DEG_W-1:0]  DEG_P180 = 9'sd180;
  localparam logic signed [DEG_W-1:0]  DEG_P90  = 9'sd90;
  localparam logic signed [DEG_W-1:0]  DEG_N90  = -9'sd90;
  localparam logic signed [DEG_W-1:0]  DEG_ZERO = 9'sd0;

  // Configuration register index
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ANGLE_OFFSET  = 3'd0,
    CFG_UPPER_LIMIT   = 3'd1,
    CFG_LOWER_LIMIT   = 3'd2,
    CFG_CONFIRM_COUNT = 3'd3,
    CFG_ALARM_INTERVAL = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic signed [DEG_W-1:0]  angle_offset;
    logic signed [TILT_W-1:0] upper_limit;
    logic signed [TILT_W-1:0] lower_limit;
    logic [15:0]              confirm_count;
    logic [15:0]              alarm_interval_ms;
  } cfg_regs_t;

  // Word travelling down the CORDIC cell chain
  typedef struct packed {
    logic signed [XZ_W-1:0]  x;
    logic signed [XZ_W-1:0]  z;
    logic signed [ANG_W-1:0] ang;
  } cordic_t;

  // Per-sample side info held while the sample is in the chain
  typedef struct packed {
    logic                    special;
    logic signed [DEG_W-1:0] special_deg;
    logic [TIME_W-1:0]       now_ms;
  } item_info_t;

endpackage : tad_pkg

`default_nettype wire

FILE: hw/rtl/tad_cordic_cell.sv
`default_nettype none

// One vectoring iteration of the CORDIC, registered
module tad_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire tad_pkg::cordic_t in_data,
  output logic                 out_valid,
  output tad_pkg::cordic_t     out_data
);
  import tad_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN_STEP = ANG_W'(ATAN_DEG_Q16[STEP]);

  logic signed [XZ_W-1:0] x_sh;
  logic signed [XZ_W-1:0] z_sh;
  logic                   z_zero;
  cordic_t                data_next;

  // Rotate toward z = 0; a residual of exactly zero stops rotating
  always_comb begin
    x_sh      = in_data.x >>> STEP;
    z_sh      = in_data.z >>> STEP;
    z_zero    = (in_data.z == '0);
    data_next = in_data;
    if (z_zero) begin
      data_next = in_data;
    end else if (!in_data.z[XZ_W-1]) begin
      data_next.x   = in_data.x + z_sh;
      data_next.z   = in_data.z - x_sh;
      data_next.ang = in_data.ang + ATAN_STEP;
    end else begin
      data_next.x   = in_data.x - z_sh;
      data_next.z   = in_data.z + x_sh;
      data_next.ang = in_data.ang - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule : tad_cordic_cell

`default_nettype wire

FILE: hw/rtl/tad_alarm.sv
`default_nettype none

// Angle rounding, limit check, debounce counter and speaker timing
module tad_alarm #(
  parameter int COUNT_BITS = tad_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tad_pkg::cfg_regs_t          cfg,
  input  wire logic                        ang_valid,
  input  wire logic signed [tad_pkg::ANG_W-1:0] ang,
  input  wire tad_pkg::item_info_t         info,
  output logic                             take,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [tad_pkg::OUT_W-1:0]        m_axis_tdata  // tilt_degrees[9:0], tilt_confirmed, speaker_on, pad
);
  import tad_pkg::*;

  localparam int MAG_W = ANG_W - FRAC_W;
  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // Stage A: whole degrees and raw tilt flag
  logic [ANG_W-1:0]          mag;
  logic [MAG_W-1:0]          q;
  logic signed [MAG_W:0]     deg_w;
  logic signed [DEG_W-1:0]   deg_clamp;
  logic signed [DEG_W-1:0]   deg_final;
  logic signed [TILT_W:0]    corr_w;
  logic signed [TILT_W-1:0]  corrected;
  logic                      raw_now;

  logic                      a_valid;
  logic signed [TILT_W-1:0]  a_tilt;
  logic                      a_raw;
  logic [TIME_W-1:0]         a_now;

  // State
  logic                      raw_tilt, raw_tilt_next;
  logic [COUNT_BITS-1:0]     agree_count, agree_count_next;
  logic                      confirmed_tilt, confirmed_tilt_next;
  logic                      alarm_level, alarm_level_next;
  logic [TIME_W-1:0]         last_alarm_time, last_alarm_time_next;
  logic [TIME_W-1:0]         due;
  logic                      out_free;

  // Truncate toward zero, clamp, then apply offset and limits
  // (limit check on the full-width difference, output keeps the low bits)
  always_comb begin
    mag   = ang[ANG_W-1] ? ANG_W'(-ang) : ang;
    q     = mag[ANG_W-1:FRAC_W];
    deg_w = ang[ANG_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (deg_w > (MAG_W+1)'(180)) begin
      deg_clamp = DEG_P180;
    end else if (deg_w < -(MAG_W+1)'(180)) begin
      deg_clamp = -DEG_P180;
    end else begin
      deg_clamp = deg_w[DEG_W-1:0];
    end
    deg_final = info.special ? info.special_deg : deg_clamp;
    corr_w    = (TILT_W+1)'(deg_final) - (TILT_W+1)'(cfg.angle_offset);
    corrected = corr_w[TILT_W-1:0];
    raw_now   = (corr_w > (TILT_W+1)'(cfg.upper_limit)) ||
                (corr_w < (TILT_W+1)'(cfg.lower_limit));
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign take     = a_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ang_valid) begin
      a_valid <= 1'b1;
    end else if (take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ang_valid) begin
      a_tilt <= corrected;
      a_raw  <= raw_now;
      a_now  <= info.now_ms;
    end
  end

  // Debounce and speaker update for the word in stage A
  always_comb begin
    raw_tilt_next        = raw_tilt;
    agree_count_next     = agree_count;
    confirmed_tilt_next  = confirmed_tilt;
    alarm_level_next     = alarm_level;
    last_alarm_time_next = last_alarm_time;
    if (a_raw == raw_tilt) begin
      if (agree_count != '1) begin
        agree_count_next = agree_count + 1'b1;
      end
    end else begin
      agree_count_next = '0;
      raw_tilt_next    = a_raw;
    end
    if (CMP_W'(agree_count_next) > CMP_W'(cfg.confirm_count)) begin
      confirmed_tilt_next = raw_tilt_next;
    end
    due = last_alarm_time + TIME_W'(cfg.alarm_interval_ms);
    if (a_now > due) begin
      alarm_level_next     = confirmed_tilt_next ? !alarm_level : 1'b0;
      last_alarm_time_next = a_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_tilt        <= 1'b0;
      agree_count     <= '0;
      confirmed_tilt  <= 1'b0;
      alarm_level     <= 1'b0;
      last_alarm_time <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (take) begin
        raw_tilt        <= raw_tilt_next;
        agree_count     <= agree_count_next;
        confirmed_tilt  <= confirmed_tilt_next;
        alarm_level     <= alarm_level_next;
        last_alarm_time <= last_alarm_time_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid   <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= {4'b0000, alarm_level_next, confirmed_tilt_next, a_tilt};
    end
  end

  // A taken word shows up on the output next cycle
  assert property (@(posedge clk) disable iff (rst) take |=> m_axis_tvalid)
    else $error("result word lost after stage A handoff");

  // Agreement counter only steps up by one, holds, or clears
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (agree_count == $past(agree_count)) ||
                    (agree_count == $past(agree_count) + 1'b1) ||
                    (agree_count == '0))
    else $error("agreement counter jumped");

endmodule : tad_alarm

`default_nettype wire

FILE: hw/rtl/tilt_angle_debounced_alarm_unit.sv
`default_nettype none

// Tilt alarm: each accepted word carries one X/Z accelerometer sample and the
// millisecond time; one result word comes back per sample with the angle
// atan2(z, x) minus the offset in whole degrees, the debounced tilt state and
// the speaker level. The angle is found by a row of CORDIC_STEPS vectoring
// cells, one iteration each; from accept to result a sample passes the prep
// register, the cell row, the rounding/limit stage and the output register.
// One sample is in the cell row at a time; the next one is accepted in the
// cycle after the previous result is loaded into the output register, which
// may still be waiting on tready. Registers are written at any edge with
// cfg_we high; the user must write them only while no sample is in flight,
// as the block itself does not enforce this.
module tilt_angle_debounced_alarm_unit #(
  parameter int CORDIC_STEPS = tad_pkg::CORDIC_STEPS_DEF,
  parameter int COUNT_BITS   = tad_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [tad_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [tad_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Sample stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [tad_pkg::IN_W-1:0]       s_axis_tdata,  // accel_x[15:0], accel_z[31:16], now_ms[63:32]
  // Result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [tad_pkg::OUT_W-1:0]           m_axis_tdata   // tilt_degrees[9:0], tilt_confirmed, speaker_on, pad
);
  import tad_pkg::*;

  localparam int EXT_W = XZ_W - (SAMPLE_W + 1) - SCALE_SH;

  cfg_regs_t  cfg;
  item_info_t info;

  logic       busy;
  logic       accept;
  logic       take;

  logic signed [SAMPLE_W-1:0] x_in;
  logic signed [SAMPLE_W-1:0] z_in;
  logic signed [SAMPLE_W:0]   x_adj;
  logic signed [SAMPLE_W:0]   z_adj;
  logic                       z_pos;
  logic                       x_pos;
  cordic_t                    prep_next;
  logic                       special_next;
  logic signed [DEG_W-1:0]    special_deg_next;

  logic    [CORDIC_STEPS:0] chain_valid;
  cordic_t                  chain_data [CORDIC_STEPS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_offset      <= '0;
      cfg.upper_limit       <= 10'sd45;
      cfg.lower_limit       <= -10'sd45;
      cfg.confirm_count     <= 16'd10;
      cfg.alarm_interval_ms <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_addr))
        CFG_ANGLE_OFFSET:   cfg.angle_offset      <= cfg_wdata[DEG_W-1:0];
        CFG_UPPER_LIMIT:    cfg.upper_limit       <= cfg_wdata[TILT_W-1:0];
        CFG_LOWER_LIMIT:    cfg.lower_limit       <= cfg_wdata[TILT_W-1:0];
        CFG_CONFIRM_COUNT:  cfg.confirm_count     <= cfg_wdata;
        CFG_ALARM_INTERVAL: cfg.alarm_interval_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One sample in flight at a time
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (take) begin
      busy <= 1'b0;
    end
  end

  // Prep: fold to the right half plane, scale, pick out the axis cases
  always_comb begin
    x_in  = s_axis_tdata[SAMPLE_W-1:0];
    z_in  = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    z_pos = !z_in[SAMPLE_W-1] && (z_in != '0);
    x_pos = !x_in[SAMPLE_W-1] && (x_in != '0);
    x_adj = x_in[SAMPLE_W-1] ? -(SAMPLE_W+1)'(x_in) : (SAMPLE_W+1)'(x_in);
    z_adj = x_in[SAMPLE_W-1] ? -(SAMPLE_W+1)'(z_in) : (SAMPLE_W+1)'(z_in);
    prep_next.x   = {{EXT_W{x_adj[SAMPLE_W]}}, x_adj, {SCALE_SH{1'b0}}};
    prep_next.z   = {{EXT_W{z_adj[SAMPLE_W]}}, z_adj, {SCALE_SH{1'b0}}};
    prep_next.ang = x_in[SAMPLE_W-1] ? (z_pos ? ANG_180 : -ANG_180) : '0;
    special_next  = (x_in == '0) || (z_in == '0);
    if (z_in == '0) begin
      special_deg_next = x_pos ? DEG_ZERO : ((x_in == '0) ? DEG_ZERO : DEG_P180);
    end else begin
      special_deg_next = z_pos ? DEG_P90 : DEG_N90;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else begin
      chain_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chain_data[0]    <= prep_next;
      info.special     <= special_next;
      info.special_deg <= special_deg_next;
      info.now_ms      <= s_axis_tdata[IN_W-1:2*SAMPLE_W];
    end
  end

  // CORDIC cell row
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    tad_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[i]),
      .in_data  (chain_data[i]),
      .out_valid(chain_valid[i+1]),
      .out_data (chain_data[i+1])
    );
  end

  tad_alarm #(
    .COUNT_BITS(COUNT_BITS)
  ) u_alarm (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ang_valid    (chain_valid[CORDIC_STEPS]),
    .ang          (chain_data[CORDIC_STEPS].ang),
    .info         (info),
    .take         (take),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // At most one sample anywhere in the cell row
  assert property (@(posedge clk) disable iff (rst) $onehot0(chain_valid))
    else $error("more than one sample in the CORDIC row");

  // A sample in the row means the input side is closed
  assert property (@(posedge clk) disable iff (rst) (|chain_valid) |-> busy)
    else $error("sample in flight while accepting");

  // An accepted sample enters the row next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> chain_valid[0])
    else $error("accepted sample did not enter the row");

endmodule : tilt_angle_debounced_alarm_unit

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tad_pkg::*;

  localparam int N_STEPS = (CORDIC_STEPS_DEF < 24) ? CORDIC_STEPS_DEF : 24;
  localparam int LATENCY = CORDIC_STEPS_DEF + 3;
  // index past the register list, must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;

  // atan(2^-i) in degrees, 16 fractional bits
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [TILT_W-1:0] deg;
    logic                     confirmed;
    logic                     speaker;
  } alarm_word_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;  // accel_x[15:0], accel_z[31:16], now_ms[63:32]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;      // tilt_degrees[9:0], tilt_confirmed, speaker_on

  tilt_angle_debounced_alarm_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor copy of the registers and the alarm state
  logic [8:0]  cfg_offset   = 9'd0;
  logic [9:0]  cfg_upper    = 10'd45;
  logic [9:0]  cfg_lower    = 10'h3D3;  // -45
  logic [15:0] cfg_confirm  = 16'd10;
  logic [15:0] cfg_interval = 16'd500;
  logic        raw_tilt     = 1'b0;
  logic [15:0] agree_cnt    = '0;
  logic        confirmed    = 1'b0;
  logic        alarm_lvl    = 1'b0;
  logic [31:0] last_alarm   = '0;

  alarm_word_t expected_alarm_q[$];
  int mismatch_cnt = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left = 0;
  logic [31:0] sim_ms = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // atan2(z, x) in whole degrees, truncated toward zero
  function automatic int cordic_deg(logic signed [15:0] ax, logic signed [15:0] az);
    longint x, z, nx, ang, base_ang, deg;
    int i;
    x = ax;
    z = az;
    ang = 0;
    base_ang = 0;
    if (x == 0 && z == 0) return 0;
    if (z == 0) return (x > 0) ? 0 : 180;
    if (x == 0) return (z > 0) ? 90 : -90;
    // left half plane: fold over and add +-180 afterwards
    if (x < 0) begin
      base_ang = (z > 0) ? 180 : -180;
      x = -x;
      z = -z;
    end
    x = x * 16384;
    z = z * 16384;
    for (i = 0; i < N_STEPS; i++) begin
      if (z == 0) break;
      if (z > 0) begin
        nx = x + (z >>> i);
        z = z - (x >>> i);
        ang = ang + ATAN_Q16[i];
      end else begin
        nx = x - (z >>> i);
        z = z + (x >>> i);
        ang = ang - ATAN_Q16[i];
      end
      x = nx;
    end
    ang = ang + base_ang * 65536;
    deg = (ang >= 0) ? (ang >>> 16) : -((-ang) >>> 16);
    if (deg > 180) deg = 180;
    if (deg < -180) deg = -180;
    return int'(deg);
  endfunction

  // Advance the debounce and alarm state by one sample, return the result word
  function automatic alarm_word_t predict_alarm_word(logic [IN_W-1:0] w);
    alarm_word_t r;
    int corrected;
    logic raw;
    logic [31:0] due;
    corrected = cordic_deg(w[15:0], w[31:16]) - int'($signed(cfg_offset));
    raw = (corrected > int'($signed(cfg_upper))) || (corrected < int'($signed(cfg_lower)));
    if (raw == raw_tilt) begin
      if (agree_cnt != 16'hFFFF) agree_cnt = agree_cnt + 16'd1;
    end else begin
      agree_cnt = '0;
      raw_tilt = raw;
    end
    if (agree_cnt > cfg_confirm) confirmed = raw_tilt;
    due = last_alarm + 32'(cfg_interval);
    if (w[63:32] > due) begin
      alarm_lvl = confirmed ? ~alarm_lvl : 1'b0;
      last_alarm = w[63:32];
    end
    r.deg = corrected[9:0];
    r.confirmed = confirmed;
    r.speaker = alarm_lvl;
    return r;
  endfunction

  // Receiver: random stalls, plus a counted hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_axis_tready <= (int'($urandom_range(99)) >= rcv_stall_pct);
      end
    end
  end

  // Predict on each accepted sample, check each accepted result
  always @(posedge clk) begin
    alarm_word_t exp_w;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_alarm_q.push_back(predict_alarm_word(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_alarm_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result word %h at %0t", m_axis_tdata, $realtime);
        end else begin
          exp_w = expected_alarm_q.pop_front();
          if (m_axis_tdata[9:0] !== exp_w.deg || m_axis_tdata[10] !== exp_w.confirmed ||
              m_axis_tdata[11] !== exp_w.speaker) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch at %0t: exp deg=%0d conf=%0b spk=%0b, got deg=%0d conf=%0b spk=%0b",
                       $realtime, exp_w.deg, exp_w.confirmed, exp_w.speaker,
                       $signed(m_axis_tdata[9:0]), m_axis_tdata[10], m_axis_tdata[11]);
          end
        end
      end
    end
  end

  // Offer one sample word, return once it is taken
  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] az,
                             input logic [31:0] t);
    while (int'($urandom_range(99)) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {t, az, ax};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stop sending and let every result come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_alarm_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      CFG_ANGLE_OFFSET:   cfg_offset = data[8:0];
      CFG_UPPER_LIMIT:    cfg_upper = data[9:0];
      CFG_LOWER_LIMIT:    cfg_lower = data[9:0];
      CFG_CONFIRM_COUNT:  cfg_confirm = data;
      CFG_ALARM_INTERVAL: cfg_interval = data;
      default: ;
    endcase
  endtask

  // Write all five registers; block must be idle
  task automatic set_config(input logic [15:0] off, input logic [15:0] up,
                            input logic [15:0] lo, input logic [15:0] conf,
                            input logic [15:0] intv, input logic spare);
    write_reg(CFG_ANGLE_OFFSET, off);
    write_reg(CFG_UPPER_LIMIT, up);
    write_reg(CFG_LOWER_LIMIT, lo);
    write_reg(CFG_CONFIRM_COUNT, conf);
    write_reg(CFG_ALARM_INTERVAL, intv);
    if (spare) write_reg(CFG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] jitter(logic signed [15:0] v);
    int j;
    j = int'(v) + int'($urandom_range(64)) - 32;
    if (j > 32767) j = 32767;
    if (j < -32768) j = -32768;
    return 16'(j);
  endfunction

  function automatic logic [31:0] next_time();
    sim_ms = sim_ms + 32'($urandom_range(2 * int'(cfg_interval) + 4));
    return sim_ms;
  endfunction

  // Axis cases, corners and the deadline wrap at reset settings
  task automatic test_directed();
    logic signed [15:0] xs[17] = '{0, 100, -100, 0, 0, 32767, -32768, -32768, 32767,
                                   -32768, 0, 1, -1, -1, 1, -32768, -32768};
    logic signed [15:0] zs[17] = '{0, 0, 0, 100, -100, 32767, -32768, 32767, -32768,
                                   0, -32768, 1, 1, -1, -1, 1, -1};
    int k;
    snd_idle_pct = 10;
    rcv_stall_pct = 55;
    for (k = 0; k < 17; k++) send_sample(xs[k], zs[k], 32'(k * 260));
    // deadline past 2^32 wraps around
    send_sample(16'sd5, -16'sd3, 32'hFFFF_FF00);
    send_sample(16'sd5, 16'sd3, 32'hFFFF_FFFF);
    send_sample(-16'sd5, 16'sd3, 32'h0000_0000);
    send_sample(-16'sd5, -16'sd3, 32'h0000_0400);
    drain();
  endtask

  // Register extremes, including the full two's complement range
  task automatic test_config_extremes();
    int k;
    // everything tilted, instant confirm, update on every new time
    set_config(16'hFF00, 16'hFE00, 16'h01FF, 16'd0, 16'd0, 1'b1);
    for (k = 0; k < 12; k++)
      send_sample(16'($urandom), 16'($urandom), 32'(1000 + k * (k % 3)));
    drain();
    // nothing tilted, confirm never reached, longest interval
    set_config(16'h00FF, 16'h01FF, 16'hFE00, 16'hFFFF, 16'hFFFF, 1'b0);
    for (k = 0; k < 12; k++)
      send_sample(16'($urandom), 16'($urandom), 32'(k * 30000));
    drain();
    // ends of the documented ranges
    set_config(16'd180, 16'd360, 16'(-360), 16'd1, 16'd1, 1'b0);
    for (k = 0; k < 10; k++)
      send_sample(-16'sd20000, 16'(k * 2000 - 9000), 32'(k * 2));
    drain();
    set_config(16'(-180), 16'(-360), 16'd360, 16'd2, 16'd3, 1'b0);
    for (k = 0; k < 10; k++)
      send_sample(16'sd3000, 16'(k * 3000 - 15000), 32'(100 + k * 3));
    drain();
  endtask

  // Random settings, then runs of steady poses with jitter, axis cases and noise
  task automatic run_random(input int n_items, input int snd_pct, input int rcv_pct);
    int off, up, lo, sent, len, kind;
    logic signed [15:0] bx, bz;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    off = int'($urandom_range(360)) - 180;
    up = int'($urandom_range(200)) - 50;
    lo = int'($urandom_range(200)) - 150;
    set_config({7'($urandom), 9'(off)}, {6'($urandom), 10'(up)}, {6'($urandom), 10'(lo)},
               ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12)),
               ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300)),
               ($urandom_range(3) == 0));
    sim_ms = ($urandom_range(2) == 0) ? 32'hFFFF_F000 + 32'($urandom_range(4095)) : $urandom;
    sent = 0;
    while (sent < n_items) begin
      kind = int'($urandom_range(99));
      if (kind < 75) begin
        bx = 16'($urandom);
        bz = 16'($urandom);
        if ($urandom_range(3) == 0) begin
          bx = bx >>> $urandom_range(12);
          bz = bz >>> $urandom_range(12);
        end
        len = int'($urandom_range(1, (cfg_confirm > 20) ? 24 : int'(cfg_confirm) + 4));
        repeat (len) send_sample(jitter(bx), jitter(bz), next_time());
        sent += len;
      end else if (kind < 87) begin
        // one or both components on an axis
        bx = 16'($urandom);
        bz = 16'($urandom);
        case ($urandom_range(3))
          0: bx = '0;
          1: bz = '0;
          2: begin bx = '0; bz = '0; end
          default: bx = 16'sh8000;
        endcase
        send_sample(bx, bz, next_time());
        sent++;
      end else begin
        send_sample(16'($urandom), 16'($urandom), $urandom);
        sent++;
      end
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    int k;
    snd_idle_pct = 0;
    rcv_stall_pct = 10;
    set_config(16'd0, 16'd30, 16'(-30), 16'd2, 16'd10, 1'b0);
    hold_left = 400;
    for (k = 0; k < 40; k++)
      send_sample(16'sd1000, 16'(k * 900 - 18000), next_time());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    run_random(290, 10, 55);
    run_random(290, 10, 55);
    run_random(290, 55, 10);
    run_random(290, 55, 10);
    run_random(290, 0, 0);
    run_random(290, 0, 0);
    test_backpressure();
    if (expected_alarm_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: tilt_angle_debounced_alarm_unit.f
hw/rtl/tad_pkg.sv
hw/rtl/tad_cordic_cell.sv
hw/rtl/tad_alarm.sv
hw/rtl/tilt_angle_debounced_alarm_unit.sv
dv/tb_top.sv
